>>> rtl/core/fcgs_pkg.sv
// Shared types, constants and helpers for the four-corner gradient shader.
// No dependencies; used by the shader core and its checker.
package fcgs_pkg;

  localparam int COLOR_W = 24;   // packed corner color
  localparam int COORD_W = 12;   // column, row and size registers
  localparam int CHAN_W  = 8;    // one color channel, also one weight
  localparam int ADDR_W  = 3;    // configuration register index

  localparam int QUO_W      = 8;                       // axis weight bits
  localparam int DIV_BITS   = 2;                       // weight bits per divider stage
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  // Stage count from accepted start to the done strobe:
  // input, divider stages, weight product, weights, channel product, sum, output.
  localparam int LATENCY = 1 + DIV_STAGES + 5;

  localparam logic [CHAN_W-1:0] WGT_FULL = 8'd255;

  typedef enum logic [ADDR_W-1:0] {
    REG_TOP_LEFT     = 3'd0,
    REG_TOP_RIGHT    = 3'd1,
    REG_BOTTOM_LEFT  = 3'd2,
    REG_BOTTOM_RIGHT = 3'd3,
    REG_WIDTH        = 3'd4,
    REG_HEIGHT       = 3'd5
  } reg_idx_t;

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    logic [16:0] s;
    t = {1'b0, x} + 17'd1;
    s = t + (t >> 8);
    return s[15:8];
  endfunction

endpackage

>>> rtl/core/four_corner_gradient_shader.sv
// Four-corner bilinear gradient shader: pixel position in, blended RGB out.
// Depends on fcgs_pkg (widths, register indexes, divide-by-255 helper).
//
// Usage
//   Configuration: write corner colors (red 23:16, green 15:8, blue 7:0) and
//   the rectangle size minus one through cfg_we / cfg_addr / cfg_data. Index 0..3
//   are the top-left, top-right, bottom-left and bottom-right colors, 4 is
//   width_less_one, 5 is height_less_one; higher indexes are ignored. Write
//   only while no pixel is in flight.
//   Input: a beat is taken at each rising edge with start high and busy low.
//   column and row are clamped to the rectangle size.
//   Output: done marks one cycle carrying red, green and blue. The receiver
//   cannot hold results off, so none is ever held back.
// Timing
//   One pixel per clock sustained; the pipeline never stalls. The depth is
//   set by the axis-weight divider (column * 255 / width_less_one, two
//   quotient bits per stage over four stages) and the two multiply-then-
//   divide-by-255 steps that follow it.
// Reset
//   rst clears the configuration registers and all valid bits; busy stays
//   high during reset so no beat is taken then. Items in flight at reset are
//   dropped.
module four_corner_gradient_shader #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fcgs_pkg::COORD_W-1:0]      column,
  input  logic [fcgs_pkg::COORD_W-1:0]      row,
  output logic                              done,
  output logic [fcgs_pkg::CHAN_W-1:0]       red,
  output logic [fcgs_pkg::CHAN_W-1:0]       green,
  output logic [fcgs_pkg::CHAN_W-1:0]       blue,
  input  logic                              cfg_we,
  input  logic [fcgs_pkg::ADDR_W-1:0]       cfg_addr,
  input  logic [fcgs_pkg::COLOR_W-1:0]      cfg_data
);

  localparam int SIDE_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  // Widths wide enough to compare a size register against MAX_SIDE - 1.
  localparam int EXT_W  = (SIDE_W > fcgs_pkg::COORD_W) ? SIDE_W : fcgs_pkg::COORD_W;
  // Clamped sizes fit both the register width and the parameter width.
  localparam int DIV_W  = (SIDE_W < fcgs_pkg::COORD_W) ? SIDE_W : fcgs_pkg::COORD_W;
  localparam int REM_W  = DIV_W + fcgs_pkg::QUO_W;
  localparam int CW     = fcgs_pkg::CHAN_W;
  localparam int NSTG   = fcgs_pkg::DIV_STAGES;

  localparam logic [EXT_W-1:0] SIDE_TOP = EXT_W'(MAX_SIDE - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [fcgs_pkg::COLOR_W-1:0] corner_color [0:3];   // tl, tr, bl, br
  logic [fcgs_pkg::COORD_W-1:0] width_less_one;
  logic [fcgs_pkg::COORD_W-1:0] height_less_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_color[0] <= '0;
      corner_color[1] <= '0;
      corner_color[2] <= '0;
      corner_color[3] <= '0;
      width_less_one  <= '0;
      height_less_one <= '0;
    end else if (cfg_we) begin
      case (fcgs_pkg::reg_idx_t'(cfg_addr))
        fcgs_pkg::REG_TOP_LEFT:     corner_color[0] <= cfg_data;
        fcgs_pkg::REG_TOP_RIGHT:    corner_color[1] <= cfg_data;
        fcgs_pkg::REG_BOTTOM_LEFT:  corner_color[2] <= cfg_data;
        fcgs_pkg::REG_BOTTOM_RIGHT: corner_color[3] <= cfg_data;
        fcgs_pkg::REG_WIDTH:        width_less_one  <= cfg_data[fcgs_pkg::COORD_W-1:0];
        fcgs_pkg::REG_HEIGHT:       height_less_one <= cfg_data[fcgs_pkg::COORD_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Never stalls; only reset blocks a beat.
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Input stage: clamp sizes and positions, form the dividends pos * 255
  // ---------------------------------------------------------------------------
  logic [EXT_W-1:0] span_x_ext, span_y_ext, pos_x_ext, pos_y_ext;
  logic [DIV_W-1:0] span_x, span_y, pos_x, pos_y;
  logic [DIV_W-1:0] divisor_x, divisor_y;

  always_comb begin
    span_x_ext = EXT_W'(width_less_one);
    span_y_ext = EXT_W'(height_less_one);
    if (span_x_ext > SIDE_TOP) span_x_ext = SIDE_TOP;
    if (span_y_ext > SIDE_TOP) span_y_ext = SIDE_TOP;
    pos_x_ext = EXT_W'(column);
    pos_y_ext = EXT_W'(row);
    if (pos_x_ext > span_x_ext) pos_x_ext = span_x_ext;
    if (pos_y_ext > span_y_ext) pos_y_ext = span_y_ext;
    span_x = DIV_W'(span_x_ext);
    span_y = DIV_W'(span_y_ext);
    pos_x  = DIV_W'(pos_x_ext);
    pos_y  = DIV_W'(pos_y_ext);
    // A single column or row clamps the position to 0; dividing 0 by 1 gives
    // the required weight of 0 without a special path.
    divisor_x = (span_x == '0) ? DIV_W'(1) : span_x;
    divisor_y = (span_y == '0) ? DIV_W'(1) : span_y;
  end

  // Divisors follow the size registers; the user, not this block, keeps them still while pixels fly.
  logic [DIV_W-1:0] dvs_x, dvs_y;

  always_ff @(posedge clk) begin
    dvs_x <= divisor_x;
    dvs_y <= divisor_y;
  end

  logic                         vld_div [0:NSTG];
  logic [REM_W-1:0]             rem_x   [0:NSTG];
  logic [REM_W-1:0]             rem_y   [0:NSTG];
  logic [fcgs_pkg::QUO_W-1:0]   quo_x   [0:NSTG];
  logic [fcgs_pkg::QUO_W-1:0]   quo_y   [0:NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_div[0] <= 1'b0;
    end else begin
      vld_div[0] <= accept;
    end
    rem_x[0] <= {pos_x, 8'd0} - REM_W'(pos_x);
    rem_y[0] <= {pos_y, 8'd0} - REM_W'(pos_y);
    quo_x[0] <= '0;
    quo_y[0] <= '0;
  end

  // ---------------------------------------------------------------------------
  // Axis-weight divider: restoring division, two quotient bits per stage.
  // The quotient is below 256 since the position never exceeds the span.
  // ---------------------------------------------------------------------------
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                              input logic [REM_W-1:0] dsh);
    if (rem >= dsh) begin
      return {1'b1, rem - dsh};
    end
    return {1'b0, rem};
  endfunction

  for (genvar s = 0; s < NSTG; s++) begin : g_div
    localparam int HI = fcgs_pkg::QUO_W - 1 - fcgs_pkg::DIV_BITS * s;
    localparam int LO = HI - 1;

    logic [REM_W-1:0]           rx_a, rx_b, ry_a, ry_b;
    logic                       bx_hi, bx_lo, by_hi, by_lo;
    logic [fcgs_pkg::QUO_W-1:0] qx, qy;

    always_comb begin
      {bx_hi, rx_a} = div_step(rem_x[s], REM_W'(dvs_x) << HI);
      {bx_lo, rx_b} = div_step(rx_a,     REM_W'(dvs_x) << LO);
      {by_hi, ry_a} = div_step(rem_y[s], REM_W'(dvs_y) << HI);
      {by_lo, ry_b} = div_step(ry_a,     REM_W'(dvs_y) << LO);
      qx     = quo_x[s];
      qx[HI] = bx_hi;
      qx[LO] = bx_lo;
      qy     = quo_y[s];
      qy[HI] = by_hi;
      qy[LO] = by_lo;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_div[s+1] <= 1'b0;
      end else begin
        vld_div[s+1] <= vld_div[s];
      end
      rem_x[s+1] <= rx_b;
      rem_y[s+1] <= ry_b;
      quo_x[s+1] <= qx;
      quo_y[s+1] <= qy;
    end
  end

  // ---------------------------------------------------------------------------
  // Corner weight products: (255-wx)(255-wy), wx(255-wy), (255-wx)wy
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   wx, wy, ix, iy;
  logic            vld_wp;
  logic [2*CW-1:0] p_tl, p_tr, p_bl;

  assign wx = quo_x[NSTG];
  assign wy = quo_y[NSTG];
  assign ix = fcgs_pkg::WGT_FULL - wx;
  assign iy = fcgs_pkg::WGT_FULL - wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_wp <= 1'b0;
    end else begin
      vld_wp <= vld_div[NSTG];
    end
    p_tl <= ix * iy;
    p_tr <= wx * iy;
    p_bl <= ix * wy;
  end

  // ---------------------------------------------------------------------------
  // Corner weights: divide by 255, bottom-right takes up the rest of 255
  // ---------------------------------------------------------------------------
  logic [CW-1:0] w_tl, w_tr, w_bl;
  logic [CW+1:0] w_sum3;
  logic          vld_w;
  logic [CW-1:0] weight [0:3];

  always_comb begin
    w_tl   = fcgs_pkg::div255(p_tl);
    w_tr   = fcgs_pkg::div255(p_tr);
    w_bl   = fcgs_pkg::div255(p_bl);
    w_sum3 = (CW+2)'(w_tl) + (CW+2)'(w_tr) + (CW+2)'(w_bl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_w <= 1'b0;
    end else begin
      vld_w <= vld_wp;
    end
    weight[0] <= w_tl;
    weight[1] <= w_tr;
    weight[2] <= w_bl;
    // The three truncated weights never sum past 255.
    weight[3] <= CW'((CW+2)'(fcgs_pkg::WGT_FULL) - w_sum3);
  end

  // ---------------------------------------------------------------------------
  // Channel blend: products, sum, divide by 255
  // ---------------------------------------------------------------------------
  logic            vld_cp, vld_sum, vld_out;
  logic [2*CW-1:0] cprod [0:2][0:3];
  logic [2*CW-1:0] csum  [0:2];
  logic [CW-1:0]   chan_out [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    localparam int SHIFT = (2 - c) * CW;   // red, green, blue

    for (genvar k = 0; k < 4; k++) begin : g_corner
      always_ff @(posedge clk) begin
        cprod[c][k] <= corner_color[k][SHIFT +: CW] * weight[k];
      end
    end

    logic [2*CW+1:0] wide_sum;
    assign wide_sum = (2*CW+2)'(cprod[c][0]) + (2*CW+2)'(cprod[c][1])
                    + (2*CW+2)'(cprod[c][2]) + (2*CW+2)'(cprod[c][3]);

    always_ff @(posedge clk) begin
      // Weights sum to 255, so the blend stays within 255 * 255.
      csum[c]     <= wide_sum[2*CW-1:0];
      chan_out[c] <= fcgs_pkg::div255(csum[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_cp  <= 1'b0;
      vld_sum <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      vld_cp  <= vld_w;
      vld_sum <= vld_cp;
      vld_out <= vld_sum;
    end
  end

  assign done  = vld_out;
  assign red   = chan_out[0];
  assign green = chan_out[1];
  assign blue  = chan_out[2];

endmodule

>>> rtl/core/fcgs_checker.sv
// Port-level checker for the four-corner gradient shader, bound to the top.
// Depends on fcgs_pkg for the pipeline latency.
module fcgs_port_checks (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Every accepted beat comes out exactly one latency later.
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(fcgs_pkg::LATENCY) done)
    else $error("accepted beat did not produce a result");

  // No result without a beat accepted one latency earlier.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, fcgs_pkg::LATENCY))
    else $error("result without a matching accepted beat");

  // Reset clears the result strobe: done is low right after rst.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind four_corner_gradient_shader fcgs_port_checks u_fcgs_port_checks (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

>>> tb/sv/fcgs_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the four-corner gradient shader: mirrors the registers, predicts
// each accepted pixel and compares it with the done beats. Depends on fcgs_pkg.
module fcgs_checker
  import fcgs_pkg::*;
#(
  parameter int MAX_SIDE = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [COORD_W-1:0] column,
  input  logic [COORD_W-1:0] row,
  input  logic               done,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  input  logic               cfg_we,
  input  logic [ADDR_W-1:0]  cfg_addr,
  input  logic [COLOR_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending_pixels
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    rgb_t               rgb;
  } shaded_t;

  logic [COLOR_W-1:0] corner_tl, corner_tr, corner_bl, corner_br;
  logic [COORD_W-1:0] span_x, span_y;

  shaded_t expected_pixels[$];
  int      errors = 0;

  function automatic logic [CHAN_W-1:0] axis_weight(input logic [COORD_W-1:0] pos,
                                                    input logic [COORD_W-1:0] span);
    logic [COORD_W-1:0]        lim;
    logic [COORD_W-1:0]        p;
    logic [COORD_W+CHAN_W-1:0] scaled;
    lim = (int'(span) > MAX_SIDE - 1) ? COORD_W'(MAX_SIDE - 1) : span;
    p   = (pos > lim) ? lim : pos;
    if (lim == '0) return '0;
    scaled = {{CHAN_W{1'b0}}, p} * (COORD_W+CHAN_W)'(255);
    return CHAN_W'(scaled / {{CHAN_W{1'b0}}, lim});
  endfunction

  function automatic rgb_t shade_pixel(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] rw);
    logic [CHAN_W-1:0] wx, wy, ix, iy;
    logic [CHAN_W-1:0] w_tl, w_tr, w_bl, w_br;
    logic [17:0]       acc;
    logic [CHAN_W-1:0] ch [3];
    rgb_t              px;
    wx   = axis_weight(col, span_x);
    wy   = axis_weight(rw, span_y);
    ix   = WGT_FULL - wx;
    iy   = WGT_FULL - wy;
    w_tl = CHAN_W'((16'(ix) * 16'(iy)) / 16'd255);
    w_tr = CHAN_W'((16'(wx) * 16'(iy)) / 16'd255);
    w_bl = CHAN_W'((16'(ix) * 16'(wy)) / 16'd255);
    // the last weight soaks up the truncation so the four add to full scale
    w_br = WGT_FULL - (w_tl + w_tr + w_bl);
    for (int k = 0; k < 3; k++) begin
      acc = 18'(corner_tl[16-8*k +: 8]) * 18'(w_tl)
          + 18'(corner_tr[16-8*k +: 8]) * 18'(w_tr)
          + 18'(corner_bl[16-8*k +: 8]) * 18'(w_bl)
          + 18'(corner_br[16-8*k +: 8]) * 18'(w_br);
      ch[k] = CHAN_W'(acc / 18'd255);
    end
    px.red   = ch[0];
    px.green = ch[1];
    px.blue  = ch[2];
    return px;
  endfunction

  task automatic note_failure(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin
    shaded_t want;
    shaded_t item;
    rgb_t    got;
    if (rst) begin
      corner_tl <= '0;
      corner_tr <= '0;
      corner_bl <= '0;
      corner_br <= '0;
      span_x    <= '0;
      span_y    <= '0;
      expected_pixels.delete();
    end else begin
      if (done) begin
        got = {red, green, blue};
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("unexpected pixel r=%02h g=%02h b=%02h",
                                 got.red, got.green, got.blue));
        end else begin
          want = expected_pixels.pop_front();
          if (want.rgb.red !== got.red || want.rgb.green !== got.green ||
              want.rgb.blue !== got.blue) begin
            note_failure($sformatf(
              "pixel (%0d,%0d): expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
              want.column, want.row, want.rgb.red, want.rgb.green, want.rgb.blue,
              got.red, got.green, got.blue));
          end
        end
      end
      if (start && !busy) begin
        item.column = column;
        item.row    = row;
        item.rgb    = shade_pixel(column, row);
        expected_pixels.push_back(item);
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_TOP_LEFT:     corner_tl <= cfg_data;
          REG_TOP_RIGHT:    corner_tr <= cfg_data;
          REG_BOTTOM_LEFT:  corner_bl <= cfg_data;
          REG_BOTTOM_RIGHT: corner_br <= cfg_data;
          REG_WIDTH:        span_x    <= cfg_data[COORD_W-1:0];
          REG_HEIGHT:       span_y    <= cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
    end
    pending_pixels <= expected_pixels.size();
    fail_count     <= errors;
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the gradient shader testbench: clock, reset, register and pixel stimulus,
// watchdog and verdict. Depends on fcgs_pkg, fcgs_checker and the shader core.
module tb;
  import fcgs_pkg::*;

  localparam int MAX_SIDE       = 4096;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SEGMENTS       = 8;
  localparam int SEGMENT_ITEMS  = 150;

  // indexes past the register file; writes there must be dropped
  localparam logic [ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  logic               clk;
  logic               rst      = 1'b1;
  logic               start    = 1'b0;
  logic [COORD_W-1:0] column   = '0;
  logic [COORD_W-1:0] row      = '0;
  logic               cfg_we   = 1'b0;
  logic [ADDR_W-1:0]  cfg_addr = '0;
  logic [COLOR_W-1:0] cfg_data = '0;
  logic               busy;
  logic               done;
  logic [CHAN_W-1:0]  red, green, blue;

  int fail_count;
  int pending_pixels;
  int quiet_cycles = 0;

  four_corner_gradient_shader #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .column   (column),
    .row      (row),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  fcgs_checker #(.MAX_SIDE(MAX_SIDE)) u_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .column         (column),
    .row            (row),
    .done           (done),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_pixels (pending_pixels)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort when neither an input beat nor a done beat shows up for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Present one pixel and hold it until the core takes the beat. Return in the
  // step of the accepting edge with start still high, so a back-to-back beat
  // can follow without a second assignment to start in that step.
  task automatic send_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
    start  <= 1'b1;
    column <= c;
    row    <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // While a random draw stays below pct, drop start and idle, scrambling the
  // position ports meanwhile; the core must ignore them.
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start  <= 1'b0;
      column <= COORD_W'($urandom);
      row    <= COORD_W'($urandom);
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted pixel has been seen. Advance
  // to the next edge first: the pending count is registered and trails an acceptance.
  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
  endtask

  // Write all six registers, then junk to both spare indexes. Size data carries
  // junk in its upper bits, which the core must mask off.
  task automatic program_setting(input logic [COLOR_W-1:0] tl, input logic [COLOR_W-1:0] tr,
                                 input logic [COLOR_W-1:0] bl, input logic [COLOR_W-1:0] br,
                                 input logic [COLOR_W-1:0] wdat,
                                 input logic [COLOR_W-1:0] hdat,
                                 input logic [COLOR_W-1:0] junk);
    logic [ADDR_W-1:0]  idx  [8];
    logic [COLOR_W-1:0] data [8];
    idx[0] = REG_TOP_LEFT;     data[0] = tl;
    idx[1] = REG_TOP_RIGHT;    data[1] = tr;
    idx[2] = REG_BOTTOM_LEFT;  data[2] = bl;
    idx[3] = REG_BOTTOM_RIGHT; data[3] = br;
    idx[4] = REG_WIDTH;        data[4] = wdat;
    idx[5] = REG_HEIGHT;       data[5] = hdat;
    idx[6] = REG_SPARE_LO;     data[6] = junk;
    idx[7] = REG_SPARE_HI;     data[7] = ~junk;
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= idx[i];
      cfg_data <= data[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Corner color: lean on the all-zero and all-one extremes now and then.
  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // Size word: single line, two pixels, small, full span or anything, with
  // random junk above the size bits.
  function automatic logic [COLOR_W-1:0] pick_side();
    logic [COORD_W-1:0] side;
    case ($urandom_range(9))
      0:          side = '0;
      1:          side = COORD_W'(1);
      2, 3, 4, 5: side = COORD_W'($urandom_range(40, 2));
      6:          side = '1;
      default:    side = COORD_W'($urandom);
    endcase
    return {COORD_W'($urandom), side};
  endfunction

  // Position: mostly inside the rectangle, some on its edges, some beyond it.
  function automatic logic [COORD_W-1:0] pick_pos(input logic [COORD_W-1:0] span);
    case ($urandom_range(9))
      7:       return COORD_W'($urandom);
      8:       return span;
      9:       return '0;
      default: return COORD_W'($urandom_range(int'(span), 0));
    endcase
  endfunction

  initial begin
    logic [COLOR_W-1:0] wdat, hdat;
    int                 idle_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: zero sizes make every position a single pixel, black.
    send_pixel('0, '0);
    send_pixel('1, '1);
    drain_pixels();

    // Primary corners on a full 4096 x 4096 field; size bits all ones.
    program_setting(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF,
                    24'hFFFFFF, 24'hFFFFFF, 24'h5A5A5A);
    send_pixel('0, '0);
    send_pixel('1, '0);
    send_pixel('0, '1);
    send_pixel('1, '1);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4094, 12'd4094);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'hAAA, 12'h555);
    drain_pixels();

    // Narrow field, single row: clamp positions past the right and bottom edge.
    program_setting(24'h123456, 24'hFEDCBA, 24'h00FFFF, 24'h808080,
                    24'hABC009, 24'hFFF000, 24'hA5A5A5);
    send_pixel(12'd9, 12'd0);
    send_pixel(12'd100, 12'hFFF);
    send_pixel(12'hFFF, 12'd7);
    send_pixel(12'd5, 12'd0);
    drain_pixels();

    // Single column, two rows.
    program_setting(24'hFFFFFF, 24'h000000, 24'h3C3C3C, 24'hC3C3C3,
                    24'h000000, 24'h000001, 24'hFFFFFF);
    send_pixel(12'hFFF, 12'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd3000, 12'd2);
    drain_pixels();

    // Random part: a fresh setting per segment, cycling the idle phases.
    // Phases 0 and 2 have no sender gaps (phase 2 is the receiver phase, which cannot stall).
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wdat = pick_side();
      hdat = pick_side();
      program_setting(pick_color(), pick_color(), pick_color(), pick_color(),
                      wdat, hdat, COLOR_W'($urandom));
      case (seg % 4)
        1:       idle_pct = 51;
        3:       idle_pct = 21;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // hold off mid-segment until the pipeline has emptied
        if (seg == 3 && n == SEGMENT_ITEMS / 2) drain_pixels();
        idle_gap(idle_pct);
        send_pixel(pick_pos(wdat[COORD_W-1:0]), pick_pos(hdat[COORD_W-1:0]));
      end
      drain_pixels();
    end

    // Let any stray done beat surface before the verdict.
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/fcgs_pkg.sv
rtl/core/four_corner_gradient_shader.sv
rtl/core/fcgs_checker.sv
tb/sv/fcgs_checker.sv
tb/sv/tb.sv
